>>> src/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Condition that holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");
`endif

>>> src/wfha_pkg.sv
// Package: constants and types of the worst-fit heap allocator.
package wfha_pkg;
    localparam int HEAP_BYTES = 4096;
    localparam int TAG_WORDS  = HEAP_BYTES / 2;
    localparam int AW         = $clog2(TAG_WORDS);
    localparam int TW         = 13;
    localparam int SW         = 15;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
endpackage

>>> src/wfha_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module wfha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/worstfit_heap_allocator.sv
// Top level: worst-fit boundary-tag heap allocator over a tag RAM.
// Allocate scans the blocks below the top, then finds no space, places a whole block
// or splits one; free ends on a bad address, on a header not in use, on a drop of the
// top, or after its tag writes. Each scanned tag is read in S_SRD, checked in S_SCHK.
// One request at a time: s_ready rises in the same cycle as m_valid.
// Reset (aresetn low, synchronous) zeroes the top and idles the FSM; tag RAM is not cleared.
module worstfit_heap_allocator
    import wfha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [11:0] s_request_bytes,
    input  logic [11:0] s_free_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_payload_address,
    output logic [1:0]  m_status,
    output logic [12:0] m_top_offset
);
`include "assert_macros.svh"

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_SRD   = 12'b000000000010, // scan: issue read
        S_SCHK  = 12'b000000000100, // scan: check tag
        S_PLACE = 12'b000000001000,
        S_WR2   = 12'b000000010000, // tag writes, one a cycle
        S_WR3   = 12'b000000100000,
        S_WR4   = 12'b000001000000,
        S_FHDR  = 12'b000010000000, // free: header read back
        S_FPRV  = 12'b000100000000, // free: previous footer back
        S_FNXT  = 12'b001000000000, // free: next header back
        S_FRES  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic [TW-1:0] top_reg, top_next;
    logic [SW-1:0] need_reg, need_next, cur_reg, cur_next;
    logic [SW-1:0] best_reg, best_next, bhdr_reg, bhdr_next;
    logic [SW-1:0] hdr_reg, hdr_next, size_reg, size_next;
    logic [11:0]   addr_reg, addr_next;
    logic [1:0]    st_reg, st_next;
    logic          mval_reg, mval_next;
    // result register: holds the transfer while the next request runs
    logic [11:0]   m_addr_reg, m_addr_next;
    logic [1:0]    m_st_reg, m_st_next;
    logic [TW-1:0] m_top_reg, m_top_next;
    // pending tag writes: up to four
    logic [SW-1:0] w_off_reg [4];
    logic [SW-1:0] w_off_next [4];
    logic [TW-1:0] w_val_reg, w_val_next, w_val2_reg, w_val2_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [TW-1:0] wdata, rdata;
    logic [SW-1:0] woff, roff, t_sz, rest;
    logic [SW:0]   grow;

    wfha_ram #(.WIDTH(TW), .DEPTH(TAG_WORDS)) u_tags (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // reads beyond the store return zero
    logic rd_oob_reg, rd_oob_next;
    logic [TW-1:0] rtag;
    assign rtag  = rd_oob_reg ? '0 : rdata;
    assign t_sz  = {2'b00, rtag[TW-1:1], 1'b0};
    assign raddr = roff[AW:1];
    assign waddr = woff[AW:1];
    assign rest  = best_reg - need_reg;
    assign grow  = {3'b000, top_reg} + {1'b0, need_reg};

    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = mval_reg;
    assign m_payload_address = m_addr_reg;
    assign m_status          = m_st_reg;
    assign m_top_offset      = m_top_reg;

    always_comb begin
        state_next = state_reg;
        top_next   = top_reg;
        need_next  = need_reg;
        cur_next   = cur_reg;
        best_next  = best_reg;
        bhdr_next  = bhdr_reg;
        hdr_next   = hdr_reg;
        size_next  = size_reg;
        addr_next  = addr_reg;
        st_next    = st_reg;
        mval_next  = mval_reg;
        m_addr_next = m_addr_reg;
        m_st_next   = m_st_reg;
        m_top_next  = m_top_reg;
        w_off_next = w_off_reg;
        w_val_next = w_val_reg;
        w_val2_next = w_val2_reg;
        roff       = cur_reg;
        rd_oob_next = 1'b0;
        we         = 1'b0;
        woff       = w_off_reg[0];
        wdata      = w_val_reg;

        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    addr_next = '0;
                    if (s_opcode == OP_ALLOC) begin
                        need_next = {3'b000, s_request_bytes} + SW'(8 + s_request_bytes[0]);
                        cur_next  = '0;
                        best_next = '0;
                        bhdr_next = '0;
                        state_next = S_SRD;
                    end else if (s_free_address < 12'd4 || s_free_address[0] ||
                                 {1'b0, s_free_address - 12'd4} >= top_reg) begin
                        st_next    = ST_IGNORED;
                        state_next = S_OUT;
                    end else begin
                        hdr_next   = {3'b000, s_free_address - 12'd4};
                        roff       = {3'b000, s_free_address - 12'd4};
                        state_next = S_FHDR;
                    end
                end
            end
            S_SRD: begin
                roff = cur_reg;
                if (cur_reg >= {2'b00, top_reg}) begin
                    state_next = S_PLACE;
                end else begin
                    state_next = S_SCHK;
                end
            end
            S_SCHK: begin
                if (t_sz == '0) begin
                    state_next = S_PLACE;
                end else begin
                    if (!rtag[0] && t_sz > best_reg && t_sz >= need_reg) begin
                        best_next = t_sz;
                        bhdr_next = cur_reg;
                    end
                    cur_next   = cur_reg + t_sz;
                    state_next = S_SRD;
                end
            end
            S_PLACE: begin
                if (best_reg == '0) begin
                    if (grow > (SW+1)'(HEAP_BYTES)) begin
                        st_next    = ST_NOSPACE;
                        state_next = S_OUT;
                    end else begin
                        top_next      = grow[TW-1:0];
                        addr_next     = 12'(top_reg + 13'd4);
                        w_val_next    = {need_reg[TW-1:1], 1'b1};
                        w_off_next[0] = {2'b00, top_reg};
                        w_off_next[1] = {2'b00, top_reg} + need_reg - SW'(4);
                        w_off_next[2] = w_off_next[1];
                        w_off_next[3] = w_off_next[1];
                        st_next       = ST_DONE;
                        state_next    = S_WR3;
                    end
                end else if (rest < SW'(8)) begin
                    addr_next     = 12'(bhdr_reg + SW'(4));
                    w_val_next    = {best_reg[TW-1:1], 1'b1};
                    w_off_next[0] = bhdr_reg;
                    w_off_next[1] = bhdr_reg + best_reg - SW'(4);
                    w_off_next[2] = w_off_next[1];
                    w_off_next[3] = w_off_next[1];
                    st_next       = ST_DONE;
                    state_next    = S_WR3;
                end else begin
                    addr_next     = 12'(bhdr_reg + rest + SW'(4));
                    w_val_next    = {need_reg[TW-1:1], 1'b1};
                    w_val2_next   = {rest[TW-1:1], 1'b0};
                    w_off_next[0] = bhdr_reg + rest;
                    w_off_next[1] = bhdr_reg + best_reg - SW'(4);
                    w_off_next[2] = bhdr_reg;
                    w_off_next[3] = bhdr_reg + rest - SW'(4);
                    st_next       = ST_DONE;
                    state_next    = S_WR2;
                end
            end
            S_WR2: begin
                // four writes: two used tags then two remainder tags
                we    = w_off_reg[0][SW-1:AW+1] == '0;
                woff  = w_off_reg[0];
                wdata = w_val_reg;
                w_off_next[0] = w_off_reg[1];
                w_off_next[1] = w_off_reg[2];
                w_off_next[2] = w_off_reg[3];
                state_next = S_WR4;
            end
            S_WR4: begin
                we    = w_off_reg[0][SW-1:AW+1] == '0;
                woff  = w_off_reg[0];
                wdata = w_val_reg;
                w_off_next[0] = w_off_reg[1];
                w_off_next[1] = w_off_reg[2];
                w_val_next    = w_val2_reg;
                state_next = S_WR3;
            end
            S_WR3: begin
                // two writes of w_val: header then footer
                we    = w_off_reg[0][SW-1:AW+1] == '0;
                woff  = w_off_reg[0];
                wdata = w_val_reg;
                w_off_next[0] = w_off_reg[1];
                if (w_off_reg[0] == w_off_reg[1]) begin
                    state_next = S_OUT;
                end else begin
                    w_off_next[1] = w_off_reg[1];
                    w_off_next[0] = w_off_reg[1];
                    w_off_next[2] = w_off_reg[1];
                    w_off_next[3] = w_off_reg[1];
                end
            end
            S_FHDR: begin
                if (!rtag[0] || t_sz == '0) begin
                    st_next    = ST_IGNORED;
                    state_next = S_OUT;
                end else begin
                    size_next = t_sz;
                    roff      = hdr_reg - SW'(4);
                    // offset wraps below zero: reads as an empty tag
                    rd_oob_next = (hdr_reg < SW'(4));
                    state_next = S_FPRV;
                end
            end
            S_FPRV: begin
                hdr_next = hdr_reg;
                if (hdr_reg != '0 && !rtag[0] && t_sz != '0 && t_sz <= hdr_reg) begin
                    hdr_next  = hdr_reg - t_sz;
                    size_next = size_reg + t_sz;
                end
                roff = hdr_next + size_next;
                rd_oob_next = (roff[SW-1:AW+1] != '0);
                state_next = S_FNXT;
            end
            S_FNXT: begin
                if (hdr_reg + size_reg < {2'b00, top_reg} && !rtag[0]) begin
                    size_next = size_reg + t_sz;
                end
                state_next = S_FRES;
            end
            S_FRES: begin
                st_next = ST_DONE;
                if (hdr_reg + size_reg == {2'b00, top_reg}) begin
                    top_next   = hdr_reg[TW-1:0];
                    state_next = S_OUT;
                end else begin
                    w_val_next    = {size_reg[TW-1:1], 1'b0};
                    w_off_next[0] = hdr_reg;
                    w_off_next[1] = hdr_reg + size_reg - SW'(4);
                    state_next    = S_WR3;
                end
            end
            S_OUT: begin
                if (!mval_reg || m_ready) begin
                    mval_next   = 1'b1;
                    m_addr_next = addr_reg;
                    m_st_next   = st_reg;
                    m_top_next  = top_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            top_reg   <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            top_reg   <= top_next;
            mval_reg  <= mval_next;
        end
        need_reg   <= need_next;
        cur_reg    <= cur_next;
        best_reg   <= best_next;
        bhdr_reg   <= bhdr_next;
        hdr_reg    <= hdr_next;
        size_reg   <= size_next;
        addr_reg   <= addr_next;
        st_reg     <= st_next;
        m_addr_reg <= m_addr_next;
        m_st_reg   <= m_st_next;
        m_top_reg  <= m_top_next;
        w_off_reg  <= w_off_next;
        w_val_reg  <= w_val_next;
        w_val2_reg <= w_val2_next;
        rd_oob_reg <= rd_oob_next;
    end

    `ASSERT_ALWAYS(a_top_bound, aclk, aresetn, top_reg <= TW'(HEAP_BYTES))
    `ASSERT_IMPL(a_top_even, aclk, aresetn, 1'b1, top_reg[0] == 1'b0)
    `ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != S_IDLE, !s_ready)
endmodule
